FILE: rtl/gbce_pkg.sv
// ----------------------------------------------------------------------------
// gbce_pkg
// Shared types, codes and sizes of the grid boundary condition engine.
// ----------------------------------------------------------------------------
package gbce_pkg;

    localparam int MAX_SIZE   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int DIM_W   = 5;
    localparam int COORD_W = $clog2(MAX_SIZE);
    localparam int ADDR_W  = 3 * COORD_W;
    localparam int DEPTH   = MAX_SIZE * MAX_SIZE * MAX_SIZE;
    localparam int SLAB_W  = 2 * COORD_W + 1;
    localparam int TOTAL_W = ADDR_W + 1;
    localparam int IDX_W   = 12;
    localparam int CODE_W  = 2;
    localparam int CFG_W   = 2;

    localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(MAX_SIZE);

    localparam logic [CODE_W-1:0] MODE_WRITE    = 2'd0;
    localparam logic [CODE_W-1:0] MODE_READ     = 2'd1;
    localparam logic [CODE_W-1:0] MODE_BOUNDARY = 2'd2;

    localparam logic [CODE_W-1:0] RULE_ZERO    = 2'd0;
    localparam logic [CODE_W-1:0] RULE_NEUMANN = 2'd1;
    localparam logic [CODE_W-1:0] RULE_COPY    = 2'd2;
    localparam logic [CODE_W-1:0] RULE_BAD     = 2'd3;

    localparam logic [CODE_W-1:0] AXIS_X   = 2'd0;
    localparam logic [CODE_W-1:0] AXIS_Y   = 2'd1;
    localparam logic [CODE_W-1:0] AXIS_Z   = 2'd2;
    localparam logic [CODE_W-1:0] AXIS_ALL = 2'd3;

    localparam logic [CODE_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [CODE_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [CODE_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic [CFG_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef enum logic [2:0] {
        ADDR_ITEM,
        ADDR_LO,
        ADDR_HI,
        ADDR_SRC_LO,
        ADDR_SRC_HI
    } addr_sel_t;

    typedef enum logic [1:0] {
        WDATA_ITEM,
        WDATA_ZERO,
        WDATA_RDATA
    } wdata_sel_t;

    typedef struct packed {
        logic [CODE_W-1:0]     mode;
        logic [IDX_W-1:0]      cell_index;
        logic [WORD_WIDTH-1:0] value;
        logic [CODE_W-1:0]     axis;
        logic [CODE_W-1:0]     rule;
    } gbce_item_t;

    typedef struct packed {
        logic              item_load;
        logic              mem_we;
        logic              mem_re;
        addr_sel_t         addr_sel;
        wdata_sel_t        wdata_sel;
        logic              pass_start;
        logic              pass_first;
        logic              step;
        logic              out_load;
        logic [CODE_W-1:0] res_status;
        logic              res_use_rd;
    } gbce_cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0] mode;
        logic [CODE_W-1:0] axis;
        logic [CODE_W-1:0] rule;
        logic              dims_ok;
        logic              idx_ok;
        logic              too_small;
        logic              last_pair;
        logic              last_pass;
        logic              out_free;
        logic              cfg_busy;
    } gbce_stat_t;

endpackage

FILE: rtl/gbce_if.sv
// ----------------------------------------------------------------------------
// gbce_if
// Valid/ready channels of the grid boundary condition engine.
// ----------------------------------------------------------------------------
interface gbce_item_if
    import gbce_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CODE_W-1:0]     mode;
    logic [IDX_W-1:0]      cell_index;
    logic [WORD_WIDTH-1:0] value;
    logic [CODE_W-1:0]     axis;
    logic [CODE_W-1:0]     rule;

    modport source (output valid, mode, cell_index, value, axis, rule, input ready);
    modport sink   (input valid, mode, cell_index, value, axis, rule, output ready);
endinterface

interface gbce_result_if
    import gbce_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] read_value;
    logic [CODE_W-1:0]     status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface gbce_cfg_if
    import gbce_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] index;
    logic [DIM_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/grid_boundary_condition_engine_core.sv
// ----------------------------------------------------------------------------
// grid_boundary_condition_engine_core
// Grid memory with cell write/read and zero, Neumann and copy face rules.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  item    | in  | mode, cell_index, value, axis, rule
//  result  | out | read_value, status
//  cfg     | in  | index, data (size_x, size_y, size_z)
//
//  write, read, rejected: DECODE, then RESP loads the result; next accept waits for IDLE
//  a boundary rule adds ST_SETUP per axis pass and per face pair WR_LO, WR_HI (zero)
//  or SRC_LO, WR_LO, SRC_HI, WR_HI (Neumann, copy) on the single memory port
//  a config write holds off new transactions while settle_reg counts down and sizes settle
//  reset clears control, holds off transactions via settle_reg; grid memory is undefined
//  a held result does not block the next accept; the result stalls only the sequencer
// ----------------------------------------------------------------------------
module grid_boundary_condition_engine_core
    import gbce_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    gbce_item_if.sink      item,
    gbce_result_if.source  result,
    gbce_cfg_if.sink       cfg
);

    gbce_cmd_t  cmd;
    gbce_stat_t stat;
    gbce_item_t item_data;

    assign item_data.mode       = item.mode;
    assign item_data.cell_index = item.cell_index;
    assign item_data.value      = item.value;
    assign item_data.axis       = item.axis;
    assign item_data.rule       = item.rule;

    gbce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbce_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_data),
        .cfg    (cfg),
        .result (result),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

FILE: rtl/gbce_datapath.sv
// ----------------------------------------------------------------------------
// gbce_datapath
// Grid memory, size registers, face walk address generation, result register.
// ----------------------------------------------------------------------------
module gbce_datapath
    import gbce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbce_item_t           item,
    gbce_cfg_if.sink             cfg,
    gbce_result_if.source        result,
    input  gbce_cmd_t            cmd,
    output gbce_stat_t           stat
);

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rdata_reg;

    logic [DIM_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [SLAB_W-1:0]  slab_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [1:0]         settle_reg;

    gbce_item_t         item_reg;

    logic [CODE_W-1:0]  pass_axis_reg, pass_axis_next;
    logic [COORD_W-1:0] n_in_last_reg, n_out_last_reg;
    logic [COORD_W-1:0] in_cnt_reg, out_cnt_reg;
    logic [SLAB_W-1:0]  s_in_reg, s_out_reg, stride_reg;
    logic [ADDR_W-1:0]  span_reg, lo_reg, row_reg;

    logic [DIM_W-1:0]   p_n, p_n_out, p_n_in, n_item;
    logic [SLAB_W-1:0]  p_stride, p_s_out, p_s_in;
    logic [COORD_W-1:0] p_n_last;

    logic [ADDR_W-1:0]  hi_addr, offset, mem_addr, row_step;
    logic [WORD_WIDTH-1:0] wdata;

    logic                  out_valid_reg;
    logic [WORD_WIDTH-1:0] read_value_reg;
    logic [CODE_W-1:0]     status_reg;

    logic dims_ok;

    assign cfg.ready = 1'b1;

    // size registers and derived products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
            settle_reg <= 2'd2;
        end
        else
        begin
            if (cfg.valid)
            begin
                settle_reg <= 2'd2;
                case (cfg.index)
                    CFG_SIZE_X: size_x_reg <= cfg.data;
                    CFG_SIZE_Y: size_y_reg <= cfg.data;
                    CFG_SIZE_Z: size_z_reg <= cfg.data;
                    default:    ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slab_reg  <= SLAB_W'(size_x_reg) * SLAB_W'(size_y_reg);
        total_reg <= TOTAL_W'(slab_reg) * TOTAL_W'(size_z_reg);
    end

    assign dims_ok = (size_x_reg != '0) && (size_x_reg <= SIZE_RESET)
                  && (size_y_reg != '0) && (size_y_reg <= SIZE_RESET)
                  && (size_z_reg != '0) && (size_z_reg <= SIZE_RESET);

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        case (item_reg.axis)
            AXIS_X:  n_item = size_x_reg;
            AXIS_Y:  n_item = size_y_reg;
            default: n_item = size_z_reg;
        endcase
    end

    // axis pass setup
    always_comb
    begin
        if (cmd.pass_first)
        begin
            pass_axis_next = (item_reg.axis == AXIS_ALL) ? AXIS_X : item_reg.axis;
        end
        else
        begin
            pass_axis_next = pass_axis_reg + 2'd1;
        end
        case (pass_axis_next)
            AXIS_X:
            begin
                p_n = size_x_reg;  p_stride = SLAB_W'(1);
                p_n_out = size_z_reg; p_s_out = slab_reg;
                p_n_in = size_y_reg;  p_s_in = SLAB_W'(size_x_reg);
            end
            AXIS_Y:
            begin
                p_n = size_y_reg;  p_stride = SLAB_W'(size_x_reg);
                p_n_out = size_z_reg; p_s_out = slab_reg;
                p_n_in = size_x_reg;  p_s_in = SLAB_W'(1);
            end
            default:
            begin
                p_n = size_z_reg;  p_stride = slab_reg;
                p_n_out = size_y_reg; p_s_out = SLAB_W'(size_x_reg);
                p_n_in = size_x_reg;  p_s_in = SLAB_W'(1);
            end
        endcase
        p_n_last = COORD_W'(p_n - DIM_W'(1));
    end

    assign row_step = row_reg + ADDR_W'(s_out_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
        begin
            pass_axis_reg  <= pass_axis_next;
            stride_reg     <= p_stride;
            s_in_reg       <= p_s_in;
            s_out_reg      <= p_s_out;
            n_in_last_reg  <= COORD_W'(p_n_in - DIM_W'(1));
            n_out_last_reg <= COORD_W'(p_n_out - DIM_W'(1));
            span_reg       <= ADDR_W'(ADDR_W'(p_n_last) * ADDR_W'(p_stride));
            in_cnt_reg     <= '0;
            out_cnt_reg    <= '0;
            lo_reg         <= '0;
            row_reg        <= '0;
        end
        else if (cmd.step)
        begin
            if (in_cnt_reg == n_in_last_reg)
            begin
                in_cnt_reg  <= '0;
                out_cnt_reg <= out_cnt_reg + COORD_W'(1);
                row_reg     <= row_step;
                lo_reg      <= row_step;
            end
            else
            begin
                in_cnt_reg <= in_cnt_reg + COORD_W'(1);
                lo_reg     <= lo_reg + ADDR_W'(s_in_reg);
            end
        end
    end

    // face addresses
    assign hi_addr = lo_reg + span_reg;
    assign offset  = (item_reg.rule == RULE_NEUMANN) ? ADDR_W'({stride_reg, 1'b0})
                                                     : ADDR_W'(stride_reg);

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_LO:     mem_addr = lo_reg;
            ADDR_HI:     mem_addr = hi_addr;
            ADDR_SRC_LO: mem_addr = lo_reg + offset;
            ADDR_SRC_HI: mem_addr = hi_addr - offset;
            default:     mem_addr = item_reg.cell_index;
        endcase
        case (cmd.wdata_sel)
            WDATA_ZERO:  wdata = '0;
            WDATA_RDATA: wdata = rdata_reg;
            default:     wdata = item_reg.value;
        endcase
    end

    // grid memory
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[mem_addr] <= wdata;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_value_reg <= cmd.res_use_rd ? rdata_reg : '0;
            status_reg     <= cmd.res_status;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.read_value = read_value_reg;
    assign result.status     = status_reg;

    always_comb
    begin
        stat.mode      = item_reg.mode;
        stat.axis      = item_reg.axis;
        stat.rule      = item_reg.rule;
        stat.dims_ok   = dims_ok;
        stat.idx_ok    = dims_ok && ({1'b0, item_reg.cell_index} < total_reg);
        stat.too_small = ((item_reg.rule == RULE_NEUMANN) && (n_item < DIM_W'(3)))
                      || ((item_reg.rule == RULE_COPY) && (n_item < DIM_W'(2)));
        stat.last_pair = (in_cnt_reg == n_in_last_reg) && (out_cnt_reg == n_out_last_reg);
        stat.last_pass = (item_reg.axis != AXIS_ALL) || (pass_axis_reg == AXIS_Z);
        stat.out_free  = !out_valid_reg || result.ready;
        stat.cfg_busy  = cfg.valid || (settle_reg != 2'd0);
    end

endmodule

FILE: rtl/gbce_ctrl.sv
// ----------------------------------------------------------------------------
// gbce_ctrl
// Sequencer: decodes a transaction, walks the face pairs, loads the result.
// ----------------------------------------------------------------------------
module gbce_ctrl
    import gbce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  gbce_stat_t stat,
    output gbce_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_SETUP  = 8'b0000_0100,
        ST_SRC_LO = 8'b0000_1000,
        ST_WR_LO  = 8'b0001_0000,
        ST_SRC_HI = 8'b0010_0000,
        ST_WR_HI  = 8'b0100_0000,
        ST_RESP   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CODE_W-1:0] st_reg, st_next;
    logic              use_rd_reg, use_rd_next;
    logic              first_reg, first_next;
    logic              zero_rule;

    assign zero_rule = (stat.rule == RULE_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            st_reg     <= STATUS_OK;
            use_rd_reg <= 1'b0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            st_reg     <= st_next;
            use_rd_reg <= use_rd_next;
            first_reg  <= first_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        use_rd_next    = use_rd_reg;
        first_next     = first_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.addr_sel   = ADDR_ITEM;
        cmd.wdata_sel  = WDATA_ITEM;
        cmd.res_status = st_reg;
        cmd.res_use_rd = use_rd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.cfg_busy;
                if (in_valid && !stat.cfg_busy)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                use_rd_next = 1'b0;
                first_next  = 1'b1;
                state_next  = ST_RESP;
                case (stat.mode)
                    MODE_WRITE:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.mem_we = 1'b1;
                            st_next    = STATUS_OK;
                        end
                        else
                        begin
                            st_next = STATUS_RANGE;
                        end
                    end
                    MODE_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.mem_re  = 1'b1;
                            use_rd_next = 1'b1;
                            st_next     = STATUS_OK;
                        end
                        else
                        begin
                            st_next = STATUS_RANGE;
                        end
                    end
                    MODE_BOUNDARY:
                    begin
                        if (!stat.dims_ok || stat.rule == RULE_BAD || stat.too_small
                            || (stat.axis == AXIS_ALL && !zero_rule))
                        begin
                            st_next = STATUS_INVALID;
                        end
                        else
                        begin
                            st_next    = STATUS_OK;
                            state_next = ST_SETUP;
                        end
                    end
                    default:
                    begin
                        st_next = STATUS_INVALID;
                    end
                endcase
            end
            ST_SETUP:
            begin
                cmd.pass_start = 1'b1;
                cmd.pass_first = first_reg;
                first_next     = 1'b0;
                state_next     = zero_rule ? ST_WR_LO : ST_SRC_LO;
            end
            ST_SRC_LO:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_SRC_LO;
                state_next   = ST_WR_LO;
            end
            ST_WR_LO:
            begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_LO;
                cmd.wdata_sel = zero_rule ? WDATA_ZERO : WDATA_RDATA;
                state_next    = zero_rule ? ST_WR_HI : ST_SRC_HI;
            end
            ST_SRC_HI:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_SRC_HI;
                state_next   = ST_WR_HI;
            end
            ST_WR_HI:
            begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_HI;
                cmd.wdata_sel = zero_rule ? WDATA_ZERO : WDATA_RDATA;
                cmd.step      = 1'b1;
                if (!stat.last_pair)
                begin
                    state_next = zero_rule ? ST_WR_LO : ST_SRC_LO;
                end
                else if (!stat.last_pass)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.item_load |=> state_reg == ST_DECODE)
        else $error("transaction not followed by decode");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending one");

    a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_we && cmd.mem_re))
        else $error("memory read and write in one cycle");

    a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE && !cmd.step)
        else $error("sequencer busy after result");

endmodule
